FILE: design/sbclp_pkg.sv
// Package for the serial bus command line parser.
// Holds shared constants, the event kind type and the decode result struct.
// No dependencies.
package sbclp_pkg;

  // Default line store depth
  localparam int unsigned LINE_BYTES_DEF = 20;
  // Fixed positions that the decoder looks at
  localparam int unsigned DEC_POS = 16;
  // Line length required by the address set command
  localparam int unsigned SPA_LEN = 14;

  localparam logic [15:0] ADDR_RESET = 16'hFFFF;

  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] DIGIT_BASE = 8'd48;

  typedef enum logic [1:0] {
    EV_SEND   = 2'd0,
    EV_REPORT = 2'd1,
    EV_SET    = 2'd2
  } event_kind_e;

  typedef struct packed {
    logic        hit;
    event_kind_e kind;
    logic [15:0] group;
    logic        sw_on;
    logic        set_addr;
    logic [15:0] new_addr;
  } dec_t;

endpackage

FILE: design/sbclp_decode.sv
// Fixed-position command decoder for one complete line.
// Depends on sbclp_pkg (dec_t, event kinds, constants).
module sbclp_decode import sbclp_pkg::*; (
  input  logic [DEC_POS-1:0][7:0] line_i,
  input  logic                    len14_i,
  output dec_t                    dec_o
);

  localparam logic [7:0] ChF  = "f";
  localparam logic [7:0] ChB  = "b";
  localparam logic [7:0] ChS  = "s";
  localparam logic [7:0] ChR  = "r";
  localparam logic [7:0] ChP  = "p";
  localparam logic [7:0] ChA  = "a";
  localparam logic [7:0] Ch0  = "0";
  localparam logic [7:0] Ch1  = "1";
  localparam logic [7:0] ChSl = "/";
  localparam logic [7:0] ChEq = "=";
  localparam logic [7:0] ChDt = ".";

  logic        is_fb, is_send, is_rpa, is_spa;
  logic [15:0] w6, w7, w9, w11, w12, w13;
  logic [15:0] ga;
  logic [7:0]  b5, b6, b8, b9, b11, b12, b13;
  logic [7:0]  hi, lo;

  // digit values wrap: 16 bits are enough for the group address,
  // 8 bits for each address byte
  assign w6  = {8'h00, line_i[6]}  - {8'h00, DIGIT_BASE};
  assign w7  = {8'h00, line_i[7]}  - {8'h00, DIGIT_BASE};
  assign w9  = {8'h00, line_i[9]}  - {8'h00, DIGIT_BASE};
  assign w11 = {8'h00, line_i[11]} - {8'h00, DIGIT_BASE};
  assign w12 = {8'h00, line_i[12]} - {8'h00, DIGIT_BASE};
  assign w13 = {8'h00, line_i[13]} - {8'h00, DIGIT_BASE};

  assign ga = (((((w6 * 16'd10) + w7) * 16'd8) + w9) << 8)
            + w11 * 16'd100 + w12 * 16'd10 + w13;

  assign b5  = line_i[5]  - DIGIT_BASE;
  assign b6  = line_i[6]  - DIGIT_BASE;
  assign b8  = line_i[8]  - DIGIT_BASE;
  assign b9  = line_i[9]  - DIGIT_BASE;
  assign b11 = line_i[11] - DIGIT_BASE;
  assign b12 = line_i[12] - DIGIT_BASE;
  assign b13 = line_i[13] - DIGIT_BASE;

  assign hi = ((b5 * 8'd10) + b6) * 8'd16 + b8 * 8'd10 + b9;
  assign lo = b11 * 8'd100 + b12 * 8'd10 + b13;

  assign is_fb   = (line_i[0] == ChF) && (line_i[1] == ChB);
  assign is_send = is_fb && (line_i[2] == ChS) && (line_i[3] == Ch0) &&
                   (line_i[4] == Ch1) && (line_i[5] == ChSl) &&
                   (line_i[8] == ChSl) && (line_i[10] == ChSl) &&
                   (line_i[14] == ChEq) &&
                   ((line_i[15] == Ch0) || (line_i[15] == Ch1));
  assign is_rpa  = is_fb && (line_i[2] == ChR) && (line_i[3] == ChP) &&
                   (line_i[4] == ChA);
  assign is_spa  = is_fb && (line_i[2] == ChS) && (line_i[3] == ChP) &&
                   (line_i[4] == ChA) && (line_i[7] == ChDt) &&
                   (line_i[10] == ChDt) && len14_i;

  always_comb begin
    dec_o          = '0;
    dec_o.kind     = EV_SEND;
    dec_o.new_addr = {hi, lo};
    if (is_send) begin
      dec_o.hit   = 1'b1;
      dec_o.kind  = EV_SEND;
      dec_o.group = ga;
      dec_o.sw_on = (line_i[15] == Ch1);
    end else if (is_rpa) begin
      dec_o.hit  = 1'b1;
      dec_o.kind = EV_REPORT;
    end else if (is_spa) begin
      dec_o.hit      = 1'b1;
      dec_o.kind     = EV_SET;
      dec_o.set_addr = 1'b1;
    end
  end

endmodule

FILE: design/serial_bus_command_line_parser_unit.sv
// Top level of the serial bus command line parser.
// Depends on sbclp_pkg and sbclp_decode.
//
// Takes one received byte per cycle when not stalled and collects it into a
// line store of LINE_BYTES bytes (extra bytes are dropped). A CR directly
// followed by LF ends the line: the line is decoded at fixed positions in
// the cycle the LF is accepted and any event (send switch, report address,
// set address) appears in the output register on the next cycle. The input
// stalls only for a line-ending LF while an earlier event is still held in
// the output register by out_stall_i. Writing the config register loads the
// physical address store at once; cfg_ready_o is always high.
module serial_bus_command_line_parser_unit import sbclp_pkg::*; #(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [15:0] group_address_o,
  output logic        switch_on_o,
  output logic [15:0] phys_address_o
);

  localparam int unsigned LEN_W = $clog2(LINE_BYTES + 1);
  localparam int unsigned IDX_W = $clog2(LINE_BYTES);

  logic [LINE_BYTES-1:0][7:0] line_q, line_d;
  logic [LEN_W-1:0]           len_q, len_d;
  logic                       cr_q, cr_d;
  logic [15:0]                own_q, own_d;
  logic                       out_valid_q, out_valid_d;
  event_kind_e                kind_q;
  logic [15:0]                ga_q;
  logic                       on_q;
  logic [15:0]                phys_q;

  logic is_cr, is_lf, in_acc, line_end, out_load;
  dec_t dec;

  assign is_cr    = (rx_byte_i == CH_CR);
  assign is_lf    = (rx_byte_i == CH_LF);
  // only a line end can produce an event, so only that byte waits
  assign in_stall_o = out_valid_q & out_stall_i & is_lf & cr_q;
  assign in_acc   = in_valid_i & ~in_stall_o;
  assign line_end = in_acc & is_lf & cr_q;
  assign out_load = line_end & dec.hit;
  assign cfg_ready_o = 1'b1;

  sbclp_decode u_decode (
    .line_i  (line_q[DEC_POS-1:0]),
    .len14_i (len_q == LEN_W'(SPA_LEN)),
    .dec_o   (dec)
  );

  always_comb begin
    line_d = line_q;
    len_d  = len_q;
    cr_d   = cr_q;
    if (in_acc) begin
      if (is_cr) begin
        cr_d = 1'b1;
      end else if (is_lf) begin
        if (cr_q) begin
          line_d = '0;
          len_d  = '0;
          cr_d   = 1'b0;
        end
      end else begin
        if (len_q < LEN_W'(LINE_BYTES)) begin
          line_d[len_q[IDX_W-1:0]] = rx_byte_i;
          len_d = len_q + LEN_W'(1);
        end
        cr_d = 1'b0;
      end
    end
  end

  always_comb begin
    own_d = own_q;
    if (cfg_valid_i && cfg_ready_o) begin
      own_d = cfg_data_i;
    end else if (line_end && dec.set_addr) begin
      own_d = dec.new_addr;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '0;
      len_q       <= '0;
      cr_q        <= 1'b0;
      own_q       <= ADDR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      line_q      <= line_d;
      len_q       <= len_d;
      cr_q        <= cr_d;
      own_q       <= own_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q <= dec.kind;
      ga_q   <= dec.group;
      on_q   <= dec.sw_on;
      phys_q <= dec.set_addr ? dec.new_addr : own_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = kind_q;
  assign group_address_o = ga_q;
  assign switch_on_o     = on_q;
  assign phys_address_o  = phys_q;

endmodule

FILE: design/sbclp_checker.sv
// Port-level checks for the serial bus command line parser.
// Depends on sbclp_pkg; bound to serial_bus_command_line_parser_unit below.
module sbclp_checker import sbclp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  rx_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  event_kind_o,
  input logic [15:0] group_address_o,
  input logic        switch_on_o,
  input logic [15:0] phys_address_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(event_kind_o) &&
      $stable(group_address_o) && $stable(switch_on_o) && $stable(phys_address_o))
    else $error("stalled output item changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held output item");

  a_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && rx_byte_i != CH_LF &&
      !(out_valid_o && out_stall_i) |=> !out_valid_o)
    else $error("event produced without a line end");

  a_send_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o != EV_SEND |->
      group_address_o == 16'h0000 && !switch_on_o)
    else $error("group fields set on a non-send event");

endmodule

bind serial_bus_command_line_parser_unit sbclp_checker u_sbclp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .rx_byte_i       (rx_byte_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .event_kind_o    (event_kind_o),
  .group_address_o (group_address_o),
  .switch_on_o     (switch_on_o),
  .phys_address_o  (phys_address_o)
);

FILE: sim/tb_top.sv
// Testbench for serial_bus_command_line_parser_unit: serial command lines in,
// decoded events out, checked against an in-bench line parser model.
// Depends on sbclp_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb_top;
  import sbclp_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_BYTES = 150;

  typedef struct {
    event_kind_e kind;
    logic [15:0] group;
    logic        sw_on;
    logic [15:0] phys;
  } cmd_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  event_kind_o;
  logic [15:0] group_address_o;
  logic        switch_on_o;
  logic [15:0] phys_address_o;

  serial_bus_command_line_parser_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_kind_o    (event_kind_o),
    .group_address_o (group_address_o),
    .switch_on_o     (switch_on_o),
    .phys_address_o  (phys_address_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser model state
  logic [7:0]  line_buf [0:LINE_BYTES_DEF-1];
  int unsigned line_len = 0;
  bit          cr_pending = 1'b0;
  logic [15:0] own_addr = ADDR_RESET;

  cmd_event_t  expected_events [$];
  logic [7:0]  line_q [$];
  int unsigned bytes_sent = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          long_hold = 1'b0;
  int unsigned fail_count = 0;
  event        hold_start;

  initial begin
    foreach (line_buf[i]) line_buf[i] = '0;
  end

  function automatic logic [31:0] digit_at(int unsigned pos);
    return {24'h0, line_buf[pos]} - {24'h0, DIGIT_BASE};
  endfunction

  task automatic clear_line();
    foreach (line_buf[i]) line_buf[i] = '0;
    line_len = 0;
    cr_pending = 1'b0;
  endtask

  // Decode a finished line at its fixed positions; queue the event it yields.
  task automatic decode_line();
    cmd_event_t  ev;
    logic [31:0] ga;
    logic [31:0] hi;
    logic [31:0] lo;
    ev.group = '0;
    ev.sw_on = 1'b0;
    if (line_buf[0] != "f" || line_buf[1] != "b") return;
    if (line_buf[2] == "s" && line_buf[3] == "0" && line_buf[4] == "1" &&
        line_buf[5] == "/" && line_buf[8] == "/" && line_buf[10] == "/" &&
        line_buf[14] == "=" && (line_buf[15] == "0" || line_buf[15] == "1")) begin
      ga = digit_at(6) * 32'd10 + digit_at(7);
      ga = ga * 32'd8 + digit_at(9);
      ga = ga * 32'd256 + digit_at(11) * 32'd100 + digit_at(12) * 32'd10 + digit_at(13);
      ev.kind  = EV_SEND;
      ev.group = ga[15:0];
      ev.sw_on = (line_buf[15] == "1");
    end else if (line_buf[2] == "r" && line_buf[3] == "p" && line_buf[4] == "a") begin
      ev.kind = EV_REPORT;
    end else if (line_buf[2] == "s" && line_buf[3] == "p" && line_buf[4] == "a" &&
                 line_buf[7] == "." && line_buf[10] == "." && line_len == SPA_LEN) begin
      hi = (digit_at(5) * 32'd10 + digit_at(6)) * 32'd16 + digit_at(8) * 32'd10 + digit_at(9);
      lo = digit_at(11) * 32'd100 + digit_at(12) * 32'd10 + digit_at(13);
      own_addr = {hi[7:0], lo[7:0]};
      ev.kind  = EV_SET;
    end else begin
      return;
    end
    ev.phys = own_addr;
    expected_events.push_back(ev);
  endtask

  task automatic model_byte(input logic [7:0] b);
    if (b == CH_CR) begin
      cr_pending = 1'b1;
    end else if (b == CH_LF) begin
      if (cr_pending) begin
        decode_line();
        clear_line();
      end
    end else begin
      if (line_len < LINE_BYTES_DEF) begin
        line_buf[line_len] = b;
        line_len++;
      end
      cr_pending = 1'b0;
    end
  endtask

  // Offer one byte; valid stays high after acceptance so back-to-back items
  // never see a low pulse.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 20) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    model_byte(b);
    bytes_sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    send_byte(CH_CR);
    send_byte(CH_LF);
    line_q.delete();
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_default_addr(input logic [15:0] addr);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= addr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    own_addr = addr;
  endtask

  // Mostly a digit; now and then any byte except the line terminators.
  function automatic logic [7:0] rand_digit();
    logic [7:0] b;
    if ($urandom_range(7) == 0) begin
      b = 8'($urandom_range(255));
      if (b == CH_CR || b == CH_LF) b = "?";
    end else begin
      b = 8'("0" + $urandom_range(9));
    end
    return b;
  endfunction

  task automatic random_line();
    int unsigned sel;
    int unsigned pos;
    sel = $urandom_range(99);
    if (sel >= 85) begin
      // noise: random bytes, terminators included
      repeat ($urandom_range(24, 1)) send_byte(8'($urandom_range(255)));
      if ($urandom_range(1)) begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      return;
    end
    case ($urandom_range(2))
      0: begin
        put_text("fbs01/");
        line_q.push_back(rand_digit());
        line_q.push_back(rand_digit());
        put_text("/");
        line_q.push_back(rand_digit());
        put_text("/");
        repeat (3) line_q.push_back(rand_digit());
        put_text("=");
        line_q.push_back($urandom_range(1) ? "1" : "0");
      end
      1: begin
        put_text("fbrpa");
        repeat ($urandom_range(3)) line_q.push_back(rand_digit());
      end
      default: begin
        put_text("fbspa");
        repeat (2) line_q.push_back(rand_digit());
        put_text(".");
        repeat (2) line_q.push_back(rand_digit());
        put_text(".");
        repeat (3) line_q.push_back(rand_digit());
      end
    endcase
    if (sel >= 65) begin
      // broken variant of a well-formed line
      pos = $urandom_range(line_q.size() - 1);
      case ($urandom_range(3))
        0: line_q.delete(pos);
        1: line_q.insert(pos, 8'($urandom_range(255)));
        2: line_q[pos] = 8'($urandom_range(255));
        default: repeat ($urandom_range(10, 1)) line_q.push_back(rand_digit());
      endcase
    end
    case ($urandom_range(7))
      0: line_q.push_back(CH_CR);                 // doubled CR still ends the line
      1: line_q.push_back(CH_LF);                 // lone LF is ignored
      2: begin                                    // CR cancelled by a following byte
        line_q.push_back(CH_CR);
        line_q.push_back(rand_digit());
      end
      default: ;
    endcase
    send_line();
  endtask

  // Result checker
  always @(posedge clk_i) begin
    cmd_event_t ev;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event: kind %0d group %h phys %h",
               event_kind_o, group_address_o, phys_address_o);
        fail_count++;
      end else begin
        ev = expected_events.pop_front();
        if (event_kind_o !== ev.kind) begin
          $error("event_kind: expected %0d, actual %0d", ev.kind, event_kind_o);
          fail_count++;
        end
        if (group_address_o !== ev.group) begin
          $error("group_address: expected %h, actual %h", ev.group, group_address_o);
          fail_count++;
        end
        if (switch_on_o !== ev.sw_on) begin
          $error("switch_on: expected %0d, actual %0d", ev.sw_on, switch_on_o);
          fail_count++;
        end
        if (phys_address_o !== ev.phys) begin
          $error("phys_address: expected %h, actual %h", ev.phys, phys_address_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i)
    out_stall_i <= long_hold || ($urandom_range(99) < recv_idle_pct);

  always begin
    @(hold_start);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    long_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("[serial_bus_command_line_parser_unit] ERROR");
    $finish;
  end

  task automatic test_report_default();
    put_text("fbrpa");
    send_line();
  endtask

  task automatic test_send_switch();
    put_text("fbs01/00/0/000=0");
    send_line();
    put_text("fbs01/31/7/255=1");
    send_line();
    put_text("fbs01/99/9/999=1");               // wraps past 16 bits
    send_line();
    put_text("fbs01/z!/~/ :A=0");                // non-digits in number positions
    send_line();
  endtask

  task automatic test_set_address();
    write_default_addr(16'h0000);
    put_text("fbrpa");
    send_line();
    put_text("fbspa15.15.255");
    send_line();
    put_text("fbspa00.00.000");
    send_line();
    put_text("fbspa99.99.999");
    send_line();
    put_text("fbspa1.15.255");                  // 13 bytes: rejected
    send_line();
    put_text("fbspa15.15.2550");                // 15 bytes: rejected
    send_line();
    put_text("fbrpa");
    send_line();
  endtask

  task automatic test_line_faults();
    put_text("fb");
    line_q.push_back(CH_LF);
    put_text("rpa");
    send_line();
    put_text("fbr");
    line_q.push_back(CH_CR);
    put_text("pa");
    send_line();
    put_text("fbrpa");
    line_q.push_back(CH_CR);
    send_line();
    put_text("fbrpa");
    repeat (10) begin                           // overlong line, extreme bytes
      line_q.push_back(8'h00);
      line_q.push_back(8'hFF);
    end
    send_line();
    put_text("fb");
    send_line();
    send_line();
    put_text("xbrpa");
    send_line();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    -> hold_start;
    repeat (6) begin
      put_text("fbrpa");
      send_line();
    end
    put_text("fbs01/12/3/045=1");
    send_line();
    wait_idle();
  endtask

  task automatic test_random_lines(input int unsigned s_pct, input int unsigned r_pct,
                                   input logic [15:0] addr);
    int unsigned start;
    write_default_addr(addr);
    sender_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) random_line();
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idle_pct = 24;
    recv_idle_pct = 70;
    test_report_default();
    test_send_switch();
    test_set_address();
    test_line_faults();
    test_backpressure();
    test_random_lines(24, 70, 16'hFFFF);
    test_random_lines(70, 24, 16'($urandom_range(16'hFFFF)));
    test_random_lines(0, 0, 16'h0000);
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0)
      $display("[serial_bus_command_line_parser_unit] OK");
    else
      $display("[serial_bus_command_line_parser_unit] ERROR");
    $finish;
  end

endmodule
